/* design/sac_pkg.sv */
// Package for the stick axis calibrator: constants, register codes and shared types.
// Used by every module and interface of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sac_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_DROP = SAMPLE_W - SAMPLE_BITS;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'(({SAMPLE_W{1'b1}} >> SAMPLE_DROP) << SAMPLE_DROP);

    localparam int MARGIN_W   = 15;
    localparam int BOUND_W    = 18;
    localparam int NUM_W      = 32;
    localparam int DIV_STEPS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] POS_FULL   = 16'd65535;
    localparam logic [SAMPLE_W-1:0] POS_CENTER = 16'd32768;
    localparam logic [SAMPLE_W-1:0] POS_ZERO   = 16'd0;

    localparam logic [SAMPLE_W-1:0] RST_CAL_MIN     = 16'd500;
    localparam logic [SAMPLE_W-1:0] RST_CAL_MID     = 16'd29100;
    localparam logic [SAMPLE_W-1:0] RST_CAL_MAX     = 16'd58000;
    localparam logic [MARGIN_W-1:0] RST_MARGIN_LOW  = 15'd1500;
    localparam logic [MARGIN_W-1:0] RST_MARGIN_HIGH = 15'd1500;

    typedef enum logic [1:0] {
        REGION_CLAMP_HIGH = 2'd0,
        REGION_SCALED     = 2'd1,
        REGION_CENTER     = 2'd2,
        REGION_CLAMP_ZERO = 2'd3
    } t_region;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIPOLAR_MODE = 3'd0,
        CFG_CAL_MIN       = 3'd1,
        CFG_CAL_MID       = 3'd2,
        CFG_CAL_MAX       = 3'd3,
        CFG_MARGIN_LOW    = 3'd4,
        CFG_MARGIN_HIGH   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                unipolar;
        logic [SAMPLE_W-1:0] cal_min;
        logic [SAMPLE_W-1:0] cal_mid;
        logic [SAMPLE_W-1:0] cal_max;
        logic [MARGIN_W-1:0] margin_low;
        logic [MARGIN_W-1:0] margin_high;
    } t_cal;

    // acc holds {partial remainder, numerator bits still to shift in / quotient bits}
    typedef struct packed {
        logic [NUM_W-1:0]    acc;
        logic [SAMPLE_W-1:0] span;
        logic [SAMPLE_W-1:0] top;
        t_region             region;
        logic                fixed;
    } t_cell_data;

endpackage
`default_nettype wire

/* design/sac_in_if.sv */
// Sample channel of the stick axis calibrator: valid, ready and one raw ADC sample.
// Depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface sac_in_if;
    logic                         valid;
    logic                         ready;
    logic [sac_pkg::SAMPLE_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface
`default_nettype wire

/* design/sac_out_if.sv */
// Result channel of the stick axis calibrator: valid, ready, position and region.
// Depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface sac_out_if;
    logic                         valid;
    logic                         ready;
    logic [sac_pkg::SAMPLE_W-1:0] position;
    logic [1:0]                   region;

    modport source (output valid, output position, output region, input ready);
    modport sink   (input valid, input position, input region, output ready);
endinterface
`default_nettype wire

/* design/sac_front.sv */
// Front cells of the calibrator: segment selection, clamp tests and numerator forming.
// Three registered cells feeding the divider chain; depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sac_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sac_pkg::t_cal                i_cal,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [sac_pkg::SAMPLE_W-1:0] i_raw,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output sac_pkg::t_cell_data               o_data
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    logic signed [sac_pkg::BOUND_W-1:0] raw_s, mid_lo, mid_hi, min_lo, max_hi;
    logic signed [sac_pkg::BOUND_W-1:0] n_lo, n_hi;
    logic                               n_full, n_dead;
    logic [sac_pkg::SAMPLE_W-1:0]       n_top1;

    logic signed [sac_pkg::BOUND_W-1:0] r_raw, r_lo, r_hi;
    logic                               r_full1, r_dead;
    logic [sac_pkg::SAMPLE_W-1:0]       r_top1;

    logic signed [sac_pkg::BOUND_W-1:0] d_s, span_s;
    sac_pkg::t_region                   n_region;
    logic [sac_pkg::SAMPLE_W-1:0]       n_top2, n_d, n_span;
    logic                               n_fixed;

    sac_pkg::t_region                   r_region;
    logic [sac_pkg::SAMPLE_W-1:0]       r_top2, r_d, r_span;
    logic                               r_fixed, r_full2;

    logic [sac_pkg::NUM_W-1:0]          n_num;
    sac_pkg::t_cell_data                r_out;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    // cell 1: segment bounds
    always_comb begin
        raw_s  = $signed({2'b00, i_raw & sac_pkg::SAMPLE_MASK});
        mid_lo = $signed({2'b00, i_cal.cal_mid}) + $signed({3'b000, i_cal.margin_low});
        mid_hi = $signed({2'b00, i_cal.cal_mid}) - $signed({3'b000, i_cal.margin_high});
        min_lo = $signed({2'b00, i_cal.cal_min}) + $signed({3'b000, i_cal.margin_low});
        max_hi = $signed({2'b00, i_cal.cal_max}) - $signed({3'b000, i_cal.margin_high});
        n_lo   = min_lo;
        n_hi   = max_hi;
        n_full = 1'b0;
        n_dead = 1'b0;
        n_top1 = sac_pkg::POS_FULL;
        if (i_cal.unipolar) begin
            n_full = 1'b1;
        end else if (raw_s > mid_lo) begin
            n_lo   = mid_lo;
            n_top1 = sac_pkg::POS_CENTER;
        end else if (raw_s < mid_hi) begin
            n_hi   = mid_hi;
        end else begin
            n_dead = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
        if (rdy1 && i_valid) begin
            r_raw   <= raw_s;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_full1 <= n_full;
            r_dead  <= n_dead;
            r_top1  <= n_top1;
        end
    end

    // cell 2: clamps, offset and span
    always_comb begin
        d_s      = r_raw - r_lo;
        span_s   = r_hi - r_lo;
        n_d      = d_s[sac_pkg::SAMPLE_W-1:0];
        n_span   = span_s[sac_pkg::SAMPLE_W-1:0];
        n_fixed  = 1'b1;
        n_top2   = r_top1;
        n_region = sac_pkg::REGION_SCALED;
        if (r_dead) begin
            n_region = sac_pkg::REGION_CENTER;
            n_top2   = sac_pkg::POS_CENTER;
        end else if (r_raw < r_lo) begin
            n_region = sac_pkg::REGION_CLAMP_HIGH;
            n_top2   = sac_pkg::POS_FULL;
        end else if (r_raw > r_hi) begin
            n_region = sac_pkg::REGION_CLAMP_ZERO;
            n_top2   = sac_pkg::POS_ZERO;
        end else begin
            n_fixed  = (n_d == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (rdy2 && r_v1) begin
            r_region <= n_region;
            r_top2   <= n_top2;
            r_fixed  <= n_fixed;
            r_d      <= n_d;
            r_span   <= n_span;
            r_full2  <= r_full1;
        end
    end

    // cell 3: scale * d, 65535*d as a shift and subtract
    always_comb begin
        if (r_full2) begin
            n_num = {r_d, 16'h0000} - {16'h0000, r_d};
        end else begin
            n_num = {1'b0, r_d, 15'h0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
        if (rdy3 && r_v2) begin
            r_out.acc    <= n_num;
            r_out.span   <= r_span;
            r_out.top    <= r_top2;
            r_out.region <= r_region;
            r_out.fixed  <= r_fixed;
        end
    end

endmodule
`default_nettype wire

/* design/sac_div_cell.sv */
// One restoring-division cell: retires one quotient bit per beat and hands on the rest.
// Identical cells form the divider chain; depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sac_div_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire sac_pkg::t_cell_data i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output sac_pkg::t_cell_data      o_data
);

    logic                           r_valid;
    sac_pkg::t_cell_data            r_data, n_data;
    logic [sac_pkg::SAMPLE_W:0]     trial;
    logic [sac_pkg::SAMPLE_W:0]     diff;
    logic                           qbit;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        trial  = {i_data.acc[sac_pkg::NUM_W-1:sac_pkg::SAMPLE_W],
                  i_data.acc[sac_pkg::SAMPLE_W-1]};
        diff   = trial - {1'b0, i_data.span};
        qbit   = (trial >= {1'b0, i_data.span});
        n_data = i_data;
        if (qbit) begin
            n_data.acc = {diff[sac_pkg::SAMPLE_W-1:0],
                          i_data.acc[sac_pkg::SAMPLE_W-2:0], 1'b1};
        end else begin
            n_data.acc = {trial[sac_pkg::SAMPLE_W-1:0],
                          i_data.acc[sac_pkg::SAMPLE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

/* design/sac_out.sv */
// Output cell: rounds the quotient up, subtracts it from the segment top, holds the result.
// Last cell of the chain; depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sac_out (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire sac_pkg::t_cell_data i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [sac_pkg::SAMPLE_W-1:0] o_position,
    output logic [1:0]               o_region
);

    logic                          r_valid;
    logic [sac_pkg::SAMPLE_W-1:0]  r_position, n_position;
    sac_pkg::t_region              r_region;
    logic [sac_pkg::SAMPLE_W:0]    q_ceil;

    assign o_ready    = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_position = r_position;
    assign o_region   = r_region;

    always_comb begin
        q_ceil = {1'b0, i_data.acc[sac_pkg::SAMPLE_W-1:0]}
               + (sac_pkg::SAMPLE_W+1)'(i_data.acc[sac_pkg::NUM_W-1:sac_pkg::SAMPLE_W] != '0);
        if (i_data.fixed) begin
            n_position = i_data.top;
        end else if (q_ceil > {1'b0, i_data.top}) begin
            n_position = sac_pkg::POS_ZERO;
        end else begin
            n_position = i_data.top - q_ceil[sac_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_position <= n_position;
            r_region   <= i_data.region;
        end
    end

endmodule
`default_nettype wire

/* design/stick_axis_calibrator.sv */
// Stick axis calibrator top: calibration registers, front cells, divider chain, output cell.
// A sample passes 3 front cells, 16 divider cells and 1 output cell, each one registered.
// Throughput: one sample per cycle; each cell holds its beat only while the next is full.
// Reset (synchronous, active low) empties every cell and loads the calibration defaults.
// Depends on sac_pkg, sac_in_if, sac_out_if, sac_front, sac_div_cell, sac_out.
`timescale 1ns / 1ps
`default_nettype none
module stick_axis_calibrator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    sac_in_if.sink                              i_sample,
    sac_out_if.source                           o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [sac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sac_pkg::t_cal       r_cal;
    logic                chain_valid [sac_pkg::DIV_STEPS+1];
    logic                chain_ready [sac_pkg::DIV_STEPS+1];
    sac_pkg::t_cell_data chain_data  [sac_pkg::DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.unipolar    <= 1'b0;
            r_cal.cal_min     <= sac_pkg::RST_CAL_MIN;
            r_cal.cal_mid     <= sac_pkg::RST_CAL_MID;
            r_cal.cal_max     <= sac_pkg::RST_CAL_MAX;
            r_cal.margin_low  <= sac_pkg::RST_MARGIN_LOW;
            r_cal.margin_high <= sac_pkg::RST_MARGIN_HIGH;
        end else if (i_cfg_we) begin
            unique case (sac_pkg::t_cfg_idx'(i_cfg_idx))
                sac_pkg::CFG_UNIPOLAR_MODE: r_cal.unipolar <= i_cfg_data[0];
                sac_pkg::CFG_CAL_MIN:       r_cal.cal_min  <= i_cfg_data;
                sac_pkg::CFG_CAL_MID:       r_cal.cal_mid  <= i_cfg_data;
                sac_pkg::CFG_CAL_MAX:       r_cal.cal_max  <= i_cfg_data;
                sac_pkg::CFG_MARGIN_LOW: begin
                    r_cal.margin_low <= i_cfg_data[sac_pkg::MARGIN_W-1:0];
                end
                sac_pkg::CFG_MARGIN_HIGH: begin
                    r_cal.margin_high <= i_cfg_data[sac_pkg::MARGIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .i_valid (i_sample.valid),
        .o_ready (i_sample.ready),
        .i_raw   (i_sample.raw_sample),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_data  (chain_data[0])
    );

    for (genvar k = 0; k < sac_pkg::DIV_STEPS; k++) begin : g_div
        sac_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    sac_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (chain_valid[sac_pkg::DIV_STEPS]),
        .o_ready    (chain_ready[sac_pkg::DIV_STEPS]),
        .i_data     (chain_data[sac_pkg::DIV_STEPS]),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_position (o_result.position),
        .o_region   (o_result.region)
    );

    a_center_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.region == sac_pkg::REGION_CENTER
        |-> o_result.position == sac_pkg::POS_CENTER)
        else $error("center region without center position");

    a_clamp_high_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.region == sac_pkg::REGION_CLAMP_HIGH
        |-> o_result.position == sac_pkg::POS_FULL)
        else $error("high clamp without full-scale position");

    a_clamp_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.region == sac_pkg::REGION_CLAMP_ZERO
        |-> o_result.position == sac_pkg::POS_ZERO)
        else $error("zero clamp with nonzero position");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid && !chain_valid[0])
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
